/* rtl/febc_pkg.sv */
// Package for the FIFO-evicting block cache.
// Holds the request/response item types and command codes; no dependencies.
`timescale 1ns / 1ps

package febc_pkg;

    localparam int KEY_BITS    = 63;
    localparam int HANDLE_W    = 32;
    localparam int NUMBER_BITS = 64;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [KEY_BITS-1:0]   block_number;
        logic [HANDLE_W-1:0]   entry_handle;
    } req_t;

    typedef struct packed {
        logic                          hit;
        logic signed [NUMBER_BITS-1:0] result_number;
        logic [HANDLE_W-1:0]           result_handle;
    } rsp_t;

endpackage

/* rtl/fifo_evict_block_cache_unit.sv */
// Channel   Signals                     Direction  Item
// req       req_valid req_ready req     in         command, key, handle
// rsp       rsp_valid rsp_ready rsp     out        hit flag, key or -1, handle
//
// Each item compares the entries in order until a hit, or through all valid
// entries on a miss or a new add; an empty cache skips the comparison.
// The single-port entry memory and the one key comparator visit one entry at a
// time, reading it (S_READ) and then comparing it (S_CMP).
// Reset clears the fill count and oldest pointer; entry contents stay unwritten.
// req_ready is low from acceptance until the result enters the output register;
// a stalled result holds there and the next item is taken meanwhile.
// Fully associative cache with FIFO replacement: top level.
// Depends on febc_pkg.
`timescale 1ns / 1ps

module fifo_evict_block_cache_unit
    import febc_pkg::*;
#(
    parameter int MAX_SIZE    = 15,
    parameter int HANDLE_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int SLOTS = MAX_SIZE + 1;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int HW    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int WW    = KEY_BITS + HW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [IW-1:0]       oldest_reg;
    logic [IW-1:0]       idx_reg;
    logic                found_reg;
    logic [HW-1:0]       found_handle_reg;
    req_t                req_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic [WW-1:0]       mem [SLOTS];
    logic [WW-1:0]       rd_word_reg;

    logic                full;
    logic                out_free;
    logic                key_match;
    logic                last_entry;
    logic                wr_en;
    logic [IW-1:0]       wr_slot;
    logic [HW-1:0]       req_handle;
    logic [IW-1:0]       oldest_next;

    assign full        = (count_reg == CW'(SLOTS));
    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign key_match   = (rd_word_reg[WW-1:HW] == req_reg.block_number);
    assign last_entry  = (CW'(idx_reg) == count_reg - CW'(1));
    assign req_handle  = req_reg.entry_handle[HW-1:0];
    assign wr_slot     = full ? oldest_reg : count_reg[IW-1:0];
    assign oldest_next = (oldest_reg == IW'(SLOTS - 1)) ? '0 : oldest_reg + IW'(1);
    assign wr_en       = (state_reg == S_DONE) && out_free
                         && (req_reg.cmd == CMD_ADD) && !found_reg;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= {req_reg.block_number, req_handle};
        end
        rd_word_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= (count_reg == '0) ? S_DONE : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (key_match)
                    begin
                        found_reg        <= 1'b1;
                        found_handle_reg <= rd_word_reg[HW-1:0];
                        state_reg        <= S_DONE;
                    end
                    else if (last_entry)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_READ;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        if (req_reg.cmd == CMD_ADD)
                        begin
                            rsp_reg.hit           <= 1'b1;
                            rsp_reg.result_number <= {1'b0, req_reg.block_number};
                            rsp_reg.result_handle <= HANDLE_W'(req_handle);
                            if (!found_reg)
                            begin
                                if (full)
                                begin
                                    oldest_reg <= oldest_next;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                        end
                        else if (found_reg)
                        begin
                            rsp_reg.hit           <= 1'b1;
                            rsp_reg.result_number <= {1'b0, req_reg.block_number};
                            rsp_reg.result_handle <= HANDLE_W'(found_handle_reg);
                        end
                        else
                        begin
                            rsp_reg.hit           <= 1'b0;
                            rsp_reg.result_number <= '1;
                            rsp_reg.result_handle <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/febc_checker.sv */
// Port-level checks for the FIFO-evicting block cache, bound to the top level.
// Depends on febc_pkg and fifo_evict_block_cache_unit.
`timescale 1ns / 1ps

module febc_checker
    import febc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed while waiting");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in progress");

    a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp.result_number == -64'sd1 && rsp.result_handle == '0)
        else $error("miss response not -1 with zero handle");

    a_hit_positive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.hit |-> !rsp.result_number[63])
        else $error("hit response carries a negative number");

endmodule

bind fifo_evict_block_cache_unit febc_checker u_febc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* sim/fifo_evict_block_cache_unit_tb.sv */
// Self-checking testbench for fifo_evict_block_cache_unit: adds and lookups with
// random idling on both channels, checked against a shadow copy of the cache.
// Depends on febc_pkg and the fifo_evict_block_cache_unit RTL.
`timescale 1ns / 1ps

module fifo_evict_block_cache_unit_tb;
    import febc_pkg::*;

    localparam int SLOTS        = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_WAIT   = 40;
    localparam int ANSWER_DEPTH = 64;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    logic [KEY_BITS-1:0] shadow_keys [SLOTS];
    logic [HANDLE_W-1:0] shadow_handles [SLOTS];
    logic                shadow_valid [SLOTS];
    logic [3:0]          shadow_oldest;
    logic [4:0]          shadow_count;

    rsp_t                answer_store [ANSWER_DEPTH];
    int                  answers_in;
    int                  answers_out;
    logic [KEY_BITS-1:0] key_pool [64];
    int                  pool_size;
    int                  mismatches;
    int                  cycle_count;
    int                  rsp_hold_cycles;

    fifo_evict_block_cache_unit #(
        .MAX_SIZE    (15),
        .HANDLE_BITS (32)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_t cache_respond(input req_t item);
        rsp_t       answer;
        int         found;
        logic [3:0] slot;
        found = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (found < 0 && shadow_valid[i] && shadow_keys[i] == item.block_number)
                found = i;
        end
        if (item.cmd == CMD_ADD)
        begin
            if (found < 0)
            begin
                if (shadow_count == SLOTS)
                begin
                    slot = shadow_oldest;
                    shadow_oldest = shadow_oldest + 4'd1;
                end
                else
                begin
                    slot = shadow_oldest + shadow_count[3:0];
                    shadow_count = shadow_count + 5'd1;
                end
                shadow_keys[slot]    = item.block_number;
                shadow_handles[slot] = item.entry_handle;
                shadow_valid[slot]   = 1'b1;
            end
            answer.hit           = 1'b1;
            answer.result_number = {1'b0, item.block_number};
            answer.result_handle = item.entry_handle;
        end
        else if (found >= 0)
        begin
            answer.hit           = 1'b1;
            answer.result_number = {1'b0, item.block_number};
            answer.result_handle = shadow_handles[found];
        end
        else
        begin
            answer.hit           = 1'b0;
            answer.result_number = -64'sd1;
            answer.result_handle = '0;
        end
        return answer;
    endfunction

    function automatic logic [KEY_BITS-1:0] random_key();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[KEY_BITS-1:0];
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(3, 1);
        else if (r < 95)
            return $urandom_range(10, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    function automatic void refill_pool(input int n);
        pool_size = n;
        for (int i = 0; i < n; i++)
            key_pool[i] = random_key();
        key_pool[0] = '0;
        key_pool[1] = '1;
    endfunction

    function automatic req_t random_item(input int add_pct);
        req_t item;
        item.cmd = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_LOOKUP;
        if ($urandom_range(99) < 85)
            item.block_number = key_pool[$urandom_range(pool_size - 1)];
        else
            item.block_number = random_key();
        item.entry_handle = $urandom;
        return item;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Call at a falling edge; returns at a falling edge.
    task automatic send_item(input req_t item);
        int gap;
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        answer_store[answers_in % ANSWER_DEPTH] = cache_respond(item);
        answers_in++;
        @(negedge clk);
        gap = ($urandom_range(99) < 60) ? 0 : gap_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_op(input logic cmd, input logic [KEY_BITS-1:0] key,
                           input logic [HANDLE_W-1:0] handle);
        req_t item;
        item.cmd          = cmd;
        item.block_number = key;
        item.entry_handle = handle;
        send_item(item);
    endtask

    task automatic wait_all_answered();
        req_valid <= 1'b0;
        wait (answers_in == answers_out);
        @(negedge clk);
    endtask

    task automatic test_directed_cases();
        logic [KEY_BITS-1:0] key_max;
        logic [KEY_BITS-1:0] key_a;
        logic [KEY_BITS-1:0] key_b;
        key_max = '1;
        key_a   = KEY_BITS'({32{2'b01}});
        key_b   = KEY_BITS'({32{2'b10}});
        send_op(CMD_LOOKUP, '0, 32'hdead_beef);
        send_op(CMD_ADD, '0, '0);
        send_op(CMD_ADD, key_max, '1);
        send_op(CMD_LOOKUP, '0, '1);
        send_op(CMD_LOOKUP, key_max, '0);
        send_op(CMD_ADD, key_max, 32'h1234_5678);
        send_op(CMD_LOOKUP, key_max, 32'h0);
        send_op(CMD_LOOKUP, 63'd1, 32'h0);
        send_op(CMD_ADD, key_a, 32'ha5a5_a5a5);
        send_op(CMD_ADD, key_b, 32'h5a5a_5a5a);
        send_op(CMD_LOOKUP, key_a, 32'h0);
        send_op(CMD_LOOKUP, key_b, '1);
        send_op(CMD_ADD, '0, 32'hffff_0000);
        send_op(CMD_LOOKUP, '0, 32'h0);
        send_op(CMD_LOOKUP, ~key_max, 32'h0);
        wait_all_answered();
    endtask

    task automatic test_fill_and_evict();
        int pick;
        wait_all_answered();
        for (int round = 0; round < 4; round++)
        begin
            refill_pool(24);
            for (int i = 0; i < 24; i++)
                send_op(CMD_ADD, key_pool[i], $urandom);
            for (int i = 0; i < 24; i++)
            begin
                pick = $urandom_range(23);
                send_op(CMD_LOOKUP, key_pool[pick], $urandom);
            end
            for (int i = 0; i < 8; i++)
            begin
                pick = $urandom_range(23);
                send_op(CMD_ADD, key_pool[pick], $urandom);
                send_op(CMD_LOOKUP, key_pool[pick], $urandom);
            end
        end
        wait_all_answered();
    endtask

    task automatic test_random_mixed(input int count);
        refill_pool(48);
        for (int i = 0; i < count; i++)
            send_item(random_item(55));
    endtask

    task automatic test_small_pool(input int count);
        refill_pool(10);
        for (int i = 0; i < count; i++)
            send_item(random_item(50));
    endtask

    task automatic test_output_hold();
        refill_pool(20);
        rsp_hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_item(random_item(60));
        wait_all_answered();
    endtask

    initial
    begin : rsp_side
        int stall_left;
        int quiet_left;
        int r;
        rsp_ready  = 1'b0;
        stall_left = 0;
        quiet_left = 0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (quiet_left > 0)
                    quiet_left--;
                else
                begin
                    r = $urandom_range(99);
                    if (r < 3)
                        quiet_left = $urandom_range(200, 50);
                    else if (r < 20)
                        stall_left = gap_length();
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (answers_in == answers_out)
                report_mismatch("unexpected item", rsp.result_number, '0);
            else
            begin
                want = answer_store[answers_out % ANSWER_DEPTH];
                answers_out++;
                if (rsp.hit !== want.hit)
                    report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
                if (rsp.result_number !== want.result_number)
                    report_mismatch("result_number", rsp.result_number,
                                    want.result_number);
                if (rsp.result_handle !== want.result_handle)
                    report_mismatch("result_handle", 64'(rsp.result_handle),
                                    64'(want.result_handle));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fifo_evict_block_cache_unit test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        mismatches      = 0;
        cycle_count     = 0;
        rsp_hold_cycles = 0;
        pool_size       = 0;
        answers_in      = 0;
        answers_out     = 0;
        shadow_oldest   = '0;
        shadow_count    = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_keys[i]    = '0;
            shadow_handles[i] = '0;
            shadow_valid[i]   = 1'b0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_fill_and_evict();
        test_random_mixed(450);
        test_output_hold();
        test_small_pool(350);
        test_random_mixed(150);

        wait_all_answered();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (answers_in != answers_out)
            report_mismatch("items never returned", 64'(answers_in - answers_out), '0);
        if (mismatches == 0)
            $display("fifo_evict_block_cache_unit test passed");
        else
            $display("fifo_evict_block_cache_unit test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/febc_pkg.sv
rtl/fifo_evict_block_cache_unit.sv
rtl/febc_checker.sv
sim/fifo_evict_block_cache_unit_tb.sv
